// File: rtl/core/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and codes for the circular deque core
// Command and status codes, payload structs, the controller state type and
// the command/status structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int POOL_DEPTH_DEF = 16;

  localparam logic [2:0] CMD_PUSH_HEAD = 3'd0;
  localparam logic [2:0] CMD_PUSH_TAIL = 3'd1;
  localparam logic [2:0] CMD_POP_HEAD  = 3'd2;
  localparam logic [2:0] CMD_POP_TAIL  = 3'd3;
  localparam logic [2:0] CMD_FIND      = 3'd4;
  localparam logic [2:0] CMD_REMOVE    = 3'd5;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] result_value;
    logic [4:0]         entry_count;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ALLOC,
    OP_ALLOC_RD,
    OP_PUSH_A,
    OP_PUSH_B,
    OP_POP_START,
    OP_POP_TAIL,
    OP_UNLINK,
    OP_WALK_START,
    OP_WALK,
    OP_FINISH
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ALLOC_RD,
    S_PUSH_A,
    S_PUSH_B,
    S_POP_TAIL,
    S_UNLINK,
    S_WALK,
    S_FINISH
  } state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] status;
  } dp_ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       cnt_zero;
    logic       cnt_full;
    logic       alloc_direct;
    logic       match;
    logic       last;
  } dp_stat_t;

endpackage

// File: rtl/core/cdq_dpath.sv
// ----------------------------------------------------------------------------
// cdq_dpath: list pool datapath
// Holds the value, link and free-slot memories, the list registers and the
// result register, and carries out one step per cycle as commanded.
// ----------------------------------------------------------------------------
module cdq_dpath
  import cdq_pkg::*;
#(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_ctl_t   ctl,
  input  in_item_t  in_item,
  output dp_stat_t  stat,
  output logic      out_strobe,
  output out_item_t out_item
);

  localparam int SW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);

  logic signed [31:0] val_mem [POOL_DEPTH];
  logic [SW-1:0]      nxt_mem [POOL_DEPTH];
  logic [SW-1:0]      prv_mem [POOL_DEPTH];
  logic [SW-1:0]      fs_mem  [POOL_DEPTH];

  logic signed [31:0] val_rd_r;
  logic [SW-1:0]      nxt_rd_r, prv_rd_r, fs_rd_r;

  logic [SW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] top_r, top_nxt;
  logic [CW-1:0] wm_r, wm_nxt;
  logic [2:0]    cmd_r, cmd_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic signed [31:0] rv_r, rv_nxt;
  logic          out_strobe_r, out_strobe_nxt;
  out_item_t     out_item_r, out_item_nxt;

  logic          rd_en, fs_rd_en;
  logic [SW-1:0] ra, fs_ra;
  logic          val_we, nxt_we, prv_we, fs_we;
  logic [SW-1:0] val_wa, nxt_wa, prv_wa, fs_wa;
  logic signed [31:0] val_wd;
  logic [SW-1:0] nxt_wd, prv_wd, fs_wd;

  logic [CW-1:0]   top_dec;
  logic [CW-1:0]   dir_slot;
  logic            alloc_direct;
  logic            match;
  logic            last;
  logic [CW+4:0]   cnt_ext;

  assign top_dec      = top_r - CW'(1);
  assign dir_slot     = CW'(POOL_DEPTH - 1) - top_dec;
  // Stack positions below the low-water mark have never been written since
  // reset, so their slot number is derived from the position, not read.
  assign alloc_direct = top_dec < wm_r;
  assign match        = val_rd_r == val_r;
  assign last         = i_r == (cnt_r - CW'(1));
  assign cnt_ext      = {5'd0, cnt_nxt};

  assign stat.cmd          = cmd_r;
  assign stat.cnt_zero     = cnt_r == '0;
  assign stat.cnt_full     = cnt_r == CW'(POOL_DEPTH);
  assign stat.alloc_direct = alloc_direct;
  assign stat.match        = match;
  assign stat.last         = last;

  always_comb begin
    head_nxt       = head_r;
    cnt_nxt        = cnt_r;
    top_nxt        = top_r;
    wm_nxt         = wm_r;
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    s_nxt          = s_r;
    i_nxt          = i_r;
    rv_nxt         = rv_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    rd_en    = 1'b0;
    fs_rd_en = 1'b0;
    ra       = head_r;
    fs_ra    = top_dec[SW-1:0];
    val_we   = 1'b0;
    nxt_we   = 1'b0;
    prv_we   = 1'b0;
    fs_we    = 1'b0;
    val_wa   = s_r;
    nxt_wa   = s_r;
    prv_wa   = s_r;
    fs_wa    = top_r[SW-1:0];
    val_wd   = val_r;
    nxt_wd   = s_r;
    prv_wd   = s_r;
    fs_wd    = s_r;
    unique case (ctl.op)
      OP_NONE: begin
      end
      OP_LOAD: begin
        cmd_nxt = in_item.command;
        val_nxt = in_item.item_value;
        rv_nxt  = '0;
      end
      OP_ALLOC: begin
        top_nxt = top_dec;
        rd_en   = 1'b1;
        ra      = head_r;
        if (alloc_direct) begin
          s_nxt  = dir_slot[SW-1:0];
          wm_nxt = top_dec;
        end else begin
          fs_rd_en = 1'b1;
        end
      end
      OP_ALLOC_RD: begin
        s_nxt = fs_rd_r;
      end
      OP_PUSH_A: begin
        val_we = 1'b1;
        nxt_we = 1'b1;
        prv_we = 1'b1;
        if (cnt_r == '0) begin
          head_nxt = s_r;
          cnt_nxt  = cnt_r + CW'(1);
        end else begin
          nxt_wd = head_r;
          prv_wd = prv_rd_r;
        end
      end
      OP_PUSH_B: begin
        nxt_we  = 1'b1;
        nxt_wa  = prv_rd_r;
        prv_we  = 1'b1;
        prv_wa  = head_r;
        cnt_nxt = cnt_r + CW'(1);
        if (cmd_r == CMD_PUSH_HEAD) begin
          head_nxt = s_r;
        end
      end
      OP_POP_START: begin
        rd_en = 1'b1;
        ra    = head_r;
        s_nxt = head_r;
      end
      OP_POP_TAIL: begin
        rd_en = 1'b1;
        ra    = prv_rd_r;
        s_nxt = prv_rd_r;
      end
      OP_UNLINK: begin
        rv_nxt  = val_rd_r;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r <= CW'(1)) begin
          head_nxt = '0;
        end else begin
          nxt_we = 1'b1;
          nxt_wa = prv_rd_r;
          nxt_wd = nxt_rd_r;
          prv_we = 1'b1;
          prv_wa = nxt_rd_r;
          prv_wd = prv_rd_r;
          if (s_r == head_r) begin
            head_nxt = nxt_rd_r;
          end
        end
        if (top_r < CW'(POOL_DEPTH)) begin
          fs_we   = 1'b1;
          top_nxt = top_r + CW'(1);
        end
      end
      OP_WALK_START: begin
        rd_en = 1'b1;
        ra    = head_r;
        s_nxt = head_r;
        i_nxt = '0;
      end
      OP_WALK: begin
        // One entry per cycle: the next link just read addresses the next one.
        if (match) begin
          rv_nxt = val_rd_r;
        end else if (!last) begin
          rd_en = 1'b1;
          ra    = nxt_rd_r;
          s_nxt = nxt_rd_r;
          i_nxt = i_r + CW'(1);
        end
      end
      OP_FINISH: begin
        out_strobe_nxt            = 1'b1;
        out_item_nxt.status       = ctl.status;
        out_item_nxt.result_value = (ctl.status == ST_DONE) ? rv_r : 32'sd0;
        out_item_nxt.entry_count  = cnt_ext[4:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    if (rd_en) begin
      val_rd_r <= val_mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (rd_en) begin
      nxt_rd_r <= nxt_mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    if (rd_en) begin
      prv_rd_r <= prv_mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (fs_we) begin
      fs_mem[fs_wa] <= fs_wd;
    end
    if (fs_rd_en) begin
      fs_rd_r <= fs_mem[fs_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      cnt_r        <= '0;
      top_r        <= CW'(POOL_DEPTH);
      wm_r         <= CW'(POOL_DEPTH);
      out_strobe_r <= 1'b0;
    end else begin
      head_r       <= head_nxt;
      cnt_r        <= cnt_nxt;
      top_r        <= top_nxt;
      wm_r         <= wm_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    val_r      <= val_nxt;
    s_r        <= s_nxt;
    i_r        <= i_nxt;
    rv_r       <= rv_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// File: rtl/core/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl: command sequencer for the circular deque core
// Decodes each accepted command and steps the datapath through it, one
// datapath operation per cycle, ending with the result beat.
// ----------------------------------------------------------------------------
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_stat_t stat,
  output logic     busy,
  output dp_ctl_t  ctl
);

  state_t     state_r, state_nxt;
  logic [1:0] res_st_r, res_st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      res_st_r <= ST_DONE;
    end else begin
      state_r  <= state_nxt;
      res_st_r <= res_st_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    res_st_nxt = res_st_r;
    ctl.op     = OP_NONE;
    ctl.status = res_st_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.op    = OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        res_st_nxt = ST_DONE;
        state_nxt  = S_FINISH;
        case (stat.cmd) inside
          CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
            if (stat.cnt_full) begin
              res_st_nxt = ST_FULL;
            end else begin
              ctl.op    = OP_ALLOC;
              state_nxt = stat.alloc_direct ? S_PUSH_A : S_ALLOC_RD;
            end
          end
          CMD_POP_HEAD, CMD_POP_TAIL: begin
            if (stat.cnt_zero) begin
              res_st_nxt = ST_EMPTY;
            end else begin
              ctl.op    = OP_POP_START;
              state_nxt = (stat.cmd == CMD_POP_TAIL) ? S_POP_TAIL : S_UNLINK;
            end
          end
          CMD_FIND, CMD_REMOVE: begin
            if (stat.cnt_zero) begin
              res_st_nxt = ST_EMPTY;
            end else begin
              ctl.op    = OP_WALK_START;
              state_nxt = S_WALK;
            end
          end
          default: begin
          end
        endcase
      end
      S_ALLOC_RD: begin
        ctl.op    = OP_ALLOC_RD;
        state_nxt = S_PUSH_A;
      end
      S_PUSH_A: begin
        ctl.op    = OP_PUSH_A;
        state_nxt = stat.cnt_zero ? S_FINISH : S_PUSH_B;
      end
      S_PUSH_B: begin
        ctl.op    = OP_PUSH_B;
        state_nxt = S_FINISH;
      end
      S_POP_TAIL: begin
        ctl.op    = OP_POP_TAIL;
        state_nxt = S_UNLINK;
      end
      S_UNLINK: begin
        ctl.op    = OP_UNLINK;
        state_nxt = S_FINISH;
      end
      S_WALK: begin
        ctl.op = OP_WALK;
        if (stat.match) begin
          state_nxt = (stat.cmd == CMD_REMOVE) ? S_UNLINK : S_FINISH;
        end else if (stat.last) begin
          res_st_nxt = ST_NOTFOUND;
          state_nxt  = S_FINISH;
        end
      end
      S_FINISH: begin
        ctl.op    = OP_FINISH;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = state_r != S_IDLE;

endmodule

// File: rtl/core/circular_deque_with_value_removal_core.sv
// ----------------------------------------------------------------------------
// circular_deque_with_value_removal_core: doubly linked circular list engine
// A pool of slots holds a circular doubly linked list with push and pop at
// both ends, search by value and removal of the first matching entry.
// ----------------------------------------------------------------------------
// Usage: raise start with a command beat on in_item while busy is low; the
// beat is taken at that edge and busy rises the cycle after. Each command
// gives exactly one result beat on out_item, marked by out_strobe for one
// cycle; busy is already low during that cycle, so the next command may be
// issued alongside it. The receiver cannot stall and must take each beat.
// Controller steps from acceptance to the result beat:
//   push   : decode, a free-slot memory read when the slot is not a
//            never-used one, push A, push B unless the list was empty, finish
//   pop    : decode, a tail step at the tail only, unlink, finish
//   find   : decode, one walk step per entry up to the match or through the
//            whole entry count, finish; remove adds unlink after a match
//   empty, full and unused commands: decode, finish
// The search walks the next links one entry per cycle through the
// single registered read port of the link and value memories.
// Reset clears the list to empty with every slot free; it needs no
// clearing pass, as never-used free-stack entries are tracked by a mark.
// ----------------------------------------------------------------------------
module circular_deque_with_value_removal_core
  import cdq_pkg::*;
#(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  dp_ctl_t  ctl;
  dp_stat_t stat;

  cdq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .ctl   (ctl)
  );

  cdq_dpath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .in_item    (in_item),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result beat while a command is still in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status != ST_DONE) |-> out_item.result_value == 32'sd0)
    else $error("failed command returned a non-zero value");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_WALK) |-> !stat.cnt_zero)
    else $error("search step on an empty list");

endmodule
